[rtl/igsp_pkg.sv]
package igsp_pkg;

  localparam int MAX_STRAINS = 8;
  localparam int NUM_LABELS  = 8;
  localparam int LABEL_W     = 3;
  localparam int Q_W         = 17;
  localparam int CNT_W       = 4;
  localparam int SCNT_W      = 4;
  localparam int LANE_ID_W   = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 17;

  localparam logic [Q_W-1:0]       ONE_Q16          = 17'h10000;
  localparam logic [SCNT_W-1:0]    STRAINS_MAX      = 4'd8;
  localparam logic [CFG_IDX_W-1:0] CFG_ALT_FREQ     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRAIN_COUNT = 1'd1;

  // What one label lane found among the active strains
  typedef struct packed {
    logic has_alt;
    logic has_ref;
  } igsp_lane_flags_t;

  // Payload carried down the multiply chain
  typedef struct packed {
    logic [Q_W-1:0]        prod;
    logic [NUM_LABELS-1:0] alt_mask;
    logic [NUM_LABELS-1:0] ref_mask;
    logic                  compatible;
    logic [CNT_W-1:0]      alt_groups;
    logic [CNT_W-1:0]      ref_groups;
  } igsp_pipe_t;

  function automatic logic [CNT_W-1:0] popcount8(input logic [NUM_LABELS-1:0] v);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < NUM_LABELS; i++) begin
      c = c + CNT_W'(v[i]);
    end
    return c;
  endfunction

endpackage

[rtl/igsp_lane.sv]
module igsp_lane
  import igsp_pkg::*;
(
  input  logic [LANE_ID_W-1:0]         lane_id,
  input  logic [MAX_STRAINS-1:0]       active,
  input  logic [MAX_STRAINS-1:0]       allele_bits,
  input  logic [LABEL_W*MAX_STRAINS-1:0] group_labels,
  output igsp_lane_flags_t             flags
);

  // One lane per label: does any active member carry alt, any carry ref
  always_comb begin
    flags = '0;
    for (int s = 0; s < MAX_STRAINS; s++) begin
      if (active[s] && (group_labels[LABEL_W*s +: LABEL_W] == lane_id)) begin
        if (allele_bits[s]) begin
          flags.has_alt = 1'b1;
        end else begin
          flags.has_ref = 1'b1;
        end
      end
    end
  end

endmodule

[rtl/igsp_mul_stage.sv]
module igsp_mul_stage
  import igsp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [LANE_ID_W-1:0] stage_id,
  input  logic [Q_W-1:0]       p_factor,
  input  logic [Q_W-1:0]       q_factor,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  igsp_pipe_t           up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output igsp_pipe_t           dn_data
);

  logic                 valid_r;
  igsp_pipe_t           data_r;
  igsp_pipe_t           data_nxt;
  logic [Q_W-1:0]       factor;
  logic                 use_factor;
  logic [2*Q_W-1:0]     mult;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // Group of this stage's label: all alt takes p, all ref takes 1-p, absent passes
  always_comb begin
    use_factor = up_data.alt_mask[stage_id] || up_data.ref_mask[stage_id];
    factor     = up_data.alt_mask[stage_id] ? p_factor : q_factor;
    mult       = {{Q_W{1'b0}}, up_data.prod} * {{Q_W{1'b0}}, factor};
    data_nxt   = up_data;
    if (use_factor) begin
      data_nxt.prod = mult[16 +: Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

[rtl/ibd_group_sampling_probability.sv]
// Channel | Direction | Handshake           | Payload
// in_     | in        | in_valid / in_stall   | in_allele_bits, in_group_labels
// out_    | out       | out_valid / out_stall | out_probability, out_compatible,
//         |           |                       | out_alt_groups, out_ref_groups
// cfg_    | in        | cfg_wr_en             | cfg_index, cfg_wr_data
//
// One transaction per cycle sustained while out_stall is low; from accept to out_valid a
// transaction passes the input register (loaded at the accept edge), the lane merge
// register and eight multiply stages, one per label.
// rst_n is synchronous: empties the pipe, alt_freq to 0, strain_count to 1.
// Every stage is elastic: it loads when empty or when its successor moves, so
// a stall on out_ holds the last stage and back-pressure ripples to in_stall.
module ibd_group_sampling_probability
  import igsp_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0]           cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [MAX_STRAINS-1:0]          in_allele_bits,
  input  logic [LABEL_W*MAX_STRAINS-1:0]  in_group_labels,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [Q_W-1:0]                  out_probability,
  output logic                            out_compatible,
  output logic [CNT_W-1:0]                out_alt_groups,
  output logic [CNT_W-1:0]                out_ref_groups
);

  // Configuration
  logic [CFG_DATA_W-1:0] alt_freq_r;
  logic [SCNT_W-1:0]     strain_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alt_freq_r     <= '0;
      strain_count_r <= SCNT_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ALT_FREQ:     alt_freq_r     <= cfg_wr_data;
        CFG_STRAIN_COUNT: strain_count_r <= cfg_wr_data[SCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp p to 1.0 and strain count to the lane width
  logic [Q_W-1:0]          p_eff;
  logic [Q_W-1:0]          q_eff;
  logic [SCNT_W-1:0]       n_eff;
  logic [MAX_STRAINS-1:0]  active;

  always_comb begin
    p_eff = (alt_freq_r > ONE_Q16) ? ONE_Q16 : alt_freq_r;
    q_eff = ONE_Q16 - p_eff;
    n_eff = (strain_count_r > STRAINS_MAX) ? STRAINS_MAX : strain_count_r;
    for (int s = 0; s < MAX_STRAINS; s++) begin
      active[s] = (SCNT_W'(s) < n_eff);
    end
  end

  // Input register
  logic                           in_valid_r;
  logic                           in_ready;
  logic [MAX_STRAINS-1:0]         alleles_r;
  logic [LABEL_W*MAX_STRAINS-1:0] labels_r;
  logic                           merge_ready;

  assign in_ready = !in_valid_r || merge_ready;
  assign in_stall = !in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      alleles_r <= in_allele_bits;
      labels_r  <= in_group_labels;
    end
  end

  // Label lanes, one per group label
  igsp_lane_flags_t      lane_flags [NUM_LABELS];
  logic [NUM_LABELS-1:0] has_alt;
  logic [NUM_LABELS-1:0] has_ref;

  for (genvar g = 0; g < NUM_LABELS; g++) begin : g_lane
    igsp_lane u_lane (
      .lane_id      (LANE_ID_W'(g)),
      .active       (active),
      .allele_bits  (alleles_r),
      .group_labels (labels_r),
      .flags        (lane_flags[g])
    );
    assign has_alt[g] = lane_flags[g].has_alt;
    assign has_ref[g] = lane_flags[g].has_ref;
  end

  // Merge: compatibility and group counts. An incompatible transaction starts
  // the product at zero so the multiply chain leaves it at zero.
  igsp_pipe_t merge_nxt;
  igsp_pipe_t merge_r;
  logic       merge_valid_r;

  always_comb begin
    merge_nxt.compatible = ~|(has_alt & has_ref);
    merge_nxt.alt_mask   = has_alt & ~has_ref;
    merge_nxt.ref_mask   = has_ref & ~has_alt;
    merge_nxt.prod       = merge_nxt.compatible ? ONE_Q16 : '0;
    merge_nxt.alt_groups = merge_nxt.compatible ? popcount8(merge_nxt.alt_mask) : '0;
    merge_nxt.ref_groups = merge_nxt.compatible ? popcount8(merge_nxt.ref_mask) : '0;
  end

  logic       pipe_valid [NUM_LABELS+1];
  logic       pipe_ready [NUM_LABELS+1];
  igsp_pipe_t pipe_data  [NUM_LABELS+1];

  assign merge_ready = !merge_valid_r || pipe_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      merge_valid_r <= 1'b0;
    end else if (merge_ready) begin
      merge_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (merge_ready && in_valid_r) begin
      merge_r <= merge_nxt;
    end
  end

  assign pipe_valid[0] = merge_valid_r;
  assign pipe_data[0]  = merge_r;

  // Multiply chain in ascending label order; truncation after each step
  for (genvar g = 0; g < NUM_LABELS; g++) begin : g_mul
    igsp_mul_stage u_mul (
      .clk      (clk),
      .rst_n    (rst_n),
      .stage_id (LANE_ID_W'(g)),
      .p_factor (p_eff),
      .q_factor (q_eff),
      .up_valid (pipe_valid[g]),
      .up_ready (pipe_ready[g]),
      .up_data  (pipe_data[g]),
      .dn_valid (pipe_valid[g+1]),
      .dn_ready (pipe_ready[g+1]),
      .dn_data  (pipe_data[g+1])
    );
  end

  assign pipe_ready[NUM_LABELS] = !out_stall;

  assign out_valid       = pipe_valid[NUM_LABELS];
  assign out_probability = pipe_data[NUM_LABELS].prod;
  assign out_compatible  = pipe_data[NUM_LABELS].compatible;
  assign out_alt_groups  = pipe_data[NUM_LABELS].alt_groups;
  assign out_ref_groups  = pipe_data[NUM_LABELS].ref_groups;

  // Checks
  a_incompat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_compatible) |->
      (out_probability == '0 && out_alt_groups == '0 && out_ref_groups == '0))
    else $error("incompatible transaction with non-zero fields");

  a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_probability <= ONE_Q16))
    else $error("probability above 1.0");

  a_group_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((5'(out_alt_groups) + 5'(out_ref_groups)) <= 5'(NUM_LABELS)))
    else $error("more groups than labels");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_valid_r)
    else $error("accepted transaction not held in input register");

endmodule
